### design/crop_window_mode_vote_assert.svh
// Assertion macros for the crop window mode vote checker.
`ifndef CROP_WINDOW_MODE_VOTE_ASSERT_SVH
`define CROP_WINDOW_MODE_VOTE_ASSERT_SVH

// Property checked at every rising edge outside reset.
`define CWMV_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("crop window mode vote: assertion failed");

// Implication checked at every rising edge outside reset.
`define CWMV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  `CWMV_ASSERT(label, clk, rst_n, (ante) |=> (cons))

`endif

### design/cwmv_pkg.sv
// Shared constants and types of the crop window mode vote block.
`default_nettype none
package cwmv_pkg;

  localparam int VAL_W       = 12;
  localparam int TABLE_DEPTH = 16;
  localparam int COUNT_BITS  = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DATA_W      = 4 * VAL_W;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RAW_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RAW_HEIGHT = CFG_IDX_W'(1);

  localparam logic [VAL_W-1:0] RAW_WIDTH_RST  = VAL_W'(720);
  localparam logic [VAL_W-1:0] RAW_HEIGHT_RST = VAL_W'(576);

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef logic [VAL_W-1:0]      val_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [IDX_W-1:0]      idx_t;

  localparam cnt_t COUNT_MAX  = '1;
  localparam idx_t LAST_ENTRY = IDX_W'(TABLE_DEPTH - 1);

  // controller to datapath
  typedef struct packed {
    logic load;       // latch the incoming sample
    logic update;     // count the latched sample into the tables
    logic scan_clr;   // restart the table walk
    logic scan_step;  // visit one entry of every table
    logic finish;     // load the result register and clear the tables
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // the walk is at the last entry
    logic out_free;   // the result register can take a new item
  } sts_t;

endpackage
`default_nettype wire

### design/cwmv_table.sv
// One value table: parallel match and insert, and a one-entry-per-cycle mode search.
`default_nettype none
module cwmv_table (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           upd_i,
  input  wire cwmv_pkg::val_t value_i,
  input  wire logic           clear_i,
  input  wire logic           scan_clr_i,
  input  wire logic           scan_step_i,
  input  wire cwmv_pkg::idx_t scan_idx_i,
  input  wire logic           prefer_large_i,
  output logic                drop_o,
  output cwmv_pkg::val_t      best_o
);

  logic [cwmv_pkg::TABLE_DEPTH-1:0] valid_q;
  cwmv_pkg::val_t value_q [cwmv_pkg::TABLE_DEPTH];
  cwmv_pkg::cnt_t count_q [cwmv_pkg::TABLE_DEPTH];

  logic [cwmv_pkg::TABLE_DEPTH-1:0] match;
  logic [cwmv_pkg::TABLE_DEPTH-1:0] free_sel;
  logic hit, free_found, do_upd;

  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < cwmv_pkg::TABLE_DEPTH; i++) begin
      match[i]    = valid_q[i] && (value_q[i] == value_i);
      free_sel[i] = !valid_q[i] && !seen;
      seen        = seen | !valid_q[i];
    end
    hit        = |match;
    free_found = seen;
  end

  assign do_upd = upd_i && (value_i != '0);
  assign drop_o = do_upd && !hit && !free_found;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (do_upd && !hit) begin
      valid_q <= valid_q | free_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < cwmv_pkg::TABLE_DEPTH; i++) begin
      if (do_upd && match[i]) begin
        if (count_q[i] != cwmv_pkg::COUNT_MAX) begin
          count_q[i] <= count_q[i] + cwmv_pkg::COUNT_BITS'(1);
        end
      end else if (do_upd && !hit && free_sel[i]) begin
        value_q[i] <= value_i;
        count_q[i] <= cwmv_pkg::COUNT_BITS'(1);
      end
    end
  end

  // mode search, one entry per step
  cwmv_pkg::val_t best_val_q, rd_val;
  cwmv_pkg::cnt_t best_cnt_q, rd_cnt;
  logic           found_q, rd_valid, take;

  assign rd_valid = valid_q[scan_idx_i];
  assign rd_val   = value_q[scan_idx_i];
  assign rd_cnt   = count_q[scan_idx_i];

  always_comb begin
    take = 1'b0;
    if (rd_valid) begin
      if (!found_q || rd_cnt > best_cnt_q) begin
        take = 1'b1;
      end else if (rd_cnt == best_cnt_q) begin
        take = prefer_large_i ? (rd_val > best_val_q) : (rd_val < best_val_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q    <= 1'b0;
      best_val_q <= '0;
      best_cnt_q <= '0;
    end else if (scan_clr_i) begin
      found_q    <= 1'b0;
      best_val_q <= '0;
      best_cnt_q <= '0;
    end else if (scan_step_i && take) begin
      found_q    <= 1'b1;
      best_val_q <= rd_val;
      best_cnt_q <= rd_cnt;
    end
  end

  assign best_o = best_val_q;

endmodule
`default_nettype wire

### design/cwmv_dp.sv
// Datapath: configuration registers, sample register, four tables, walk counter, bounds check, result register.
`default_nettype none
module cwmv_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire cwmv_pkg::cmd_t                 cmd_i,
  output cwmv_pkg::sts_t                      sts_o,
  input  wire logic [cwmv_pkg::DATA_W-1:0]    sample_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [cwmv_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire cwmv_pkg::val_t                 cfg_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [cwmv_pkg::DATA_W-1:0]         out_data_o,
  output logic                                out_overflow_o
);

  cwmv_pkg::val_t raw_w_q, raw_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_w_q <= cwmv_pkg::RAW_WIDTH_RST;
      raw_h_q <= cwmv_pkg::RAW_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cwmv_pkg::REG_RAW_WIDTH:  raw_w_q <= cfg_data_i;
        cwmv_pkg::REG_RAW_HEIGHT: raw_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cwmv_pkg::val_t smp_w_q, smp_h_q, smp_x_q, smp_y_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      smp_w_q <= sample_i[0*cwmv_pkg::VAL_W +: cwmv_pkg::VAL_W];
      smp_h_q <= sample_i[1*cwmv_pkg::VAL_W +: cwmv_pkg::VAL_W];
      smp_x_q <= sample_i[2*cwmv_pkg::VAL_W +: cwmv_pkg::VAL_W];
      smp_y_q <= sample_i[3*cwmv_pkg::VAL_W +: cwmv_pkg::VAL_W];
    end
  end

  cwmv_pkg::idx_t scan_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
    end else if (cmd_i.scan_clr) begin
      scan_idx_q <= '0;
    end else if (cmd_i.scan_step) begin
      scan_idx_q <= scan_idx_q + cwmv_pkg::IDX_W'(1);
    end
  end

  logic [3:0] drop;
  cwmv_pkg::val_t best_w, best_h, best_x, best_y;

  cwmv_table u_width_table (
    .clk_i, .rst_ni,
    .upd_i(cmd_i.update), .value_i(smp_w_q), .clear_i(cmd_i.finish),
    .scan_clr_i(cmd_i.scan_clr), .scan_step_i(cmd_i.scan_step), .scan_idx_i(scan_idx_q),
    .prefer_large_i(1'b1), .drop_o(drop[0]), .best_o(best_w)
  );

  cwmv_table u_height_table (
    .clk_i, .rst_ni,
    .upd_i(cmd_i.update), .value_i(smp_h_q), .clear_i(cmd_i.finish),
    .scan_clr_i(cmd_i.scan_clr), .scan_step_i(cmd_i.scan_step), .scan_idx_i(scan_idx_q),
    .prefer_large_i(1'b1), .drop_o(drop[1]), .best_o(best_h)
  );

  cwmv_table u_left_table (
    .clk_i, .rst_ni,
    .upd_i(cmd_i.update), .value_i(smp_x_q), .clear_i(cmd_i.finish),
    .scan_clr_i(cmd_i.scan_clr), .scan_step_i(cmd_i.scan_step), .scan_idx_i(scan_idx_q),
    .prefer_large_i(1'b0), .drop_o(drop[2]), .best_o(best_x)
  );

  cwmv_table u_top_table (
    .clk_i, .rst_ni,
    .upd_i(cmd_i.update), .value_i(smp_y_q), .clear_i(cmd_i.finish),
    .scan_clr_i(cmd_i.scan_clr), .scan_step_i(cmd_i.scan_step), .scan_idx_i(scan_idx_q),
    .prefer_large_i(1'b0), .drop_o(drop[3]), .best_o(best_y)
  );

  logic overflow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overflow_q <= 1'b0;
    end else if (cmd_i.finish) begin
      overflow_q <= 1'b0;
    end else if (|drop) begin
      overflow_q <= 1'b1;
    end
  end

  // stored values are never zero, so zero means an empty table
  cwmv_pkg::val_t res_w, res_h, res_x, res_y;
  logic [cwmv_pkg::VAL_W:0] sum_x, sum_y;

  always_comb begin
    res_w = (best_w == '0) ? raw_w_q : best_w;
    res_h = (best_h == '0) ? raw_h_q : best_h;
    sum_x = {1'b0, best_x} + {1'b0, res_w};
    sum_y = {1'b0, best_y} + {1'b0, res_h};
    res_x = (sum_x > {1'b0, raw_w_q}) ? '0 : best_x;
    res_y = (sum_y > {1'b0, raw_h_q}) ? '0 : best_y;
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_o     <= {res_h, res_w, res_y, res_x};
      out_overflow_o <= overflow_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.scan_last = (scan_idx_q == cwmv_pkg::LAST_ENTRY);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule
`default_nettype wire

### design/cwmv_ctrl.sv
// Controller: takes one item at a time and sequences update, table walk and result load.
`default_nettype none
module cwmv_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_kind_i,
  output logic                in_ready_o,
  output cwmv_pkg::cmd_t      cmd_o,
  input  wire cwmv_pkg::sts_t sts_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          if (in_kind_i == cwmv_pkg::KIND_FINISH) begin
            cmd_o.scan_clr = 1'b1;
            state_d        = ST_SCAN;
          end else begin
            state_d = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        cmd_o.update = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        // wait for room in the result register
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### design/crop_window_mode_vote.sv
// Top level of the crop window mode vote block.
//
// Input stream: tuser is the item kind (0 add a sample, 1 finish); tdata carries
// width, height, x offset and y offset, 12 bits each from bit 0 up. A zero
// coordinate is not counted. Each coordinate keeps a table of distinct values
// with saturating hit counts; a new value meeting a full table is dropped and
// flagged.
// Add item: latch, then a parallel match/insert on all four tables.
// Finish item: latch, then the mode walk at one table entry per cycle, then the
// bounds check and the result register load, which waits while the previous
// result is still waiting.
// Output stream: one item per finish, tdata = crop_left, crop_top, crop_width,
// crop_height (12 bits each from bit 0 up), tuser = table overflow.
// The result register holds its item while tready is low; a new item is still
// accepted meanwhile and a later finish waits for the register to empty.
// Configuration writes (index 0 raw width, 1 raw height) are taken every cycle.
// Reset empties all tables, clears the overflow flag and loads 720 x 576.
`default_nettype none
module crop_window_mode_vote (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // width[11:0], height[23:12], x_offset[35:24], y_offset[47:36]
  input  wire logic [cwmv_pkg::DATA_W-1:0]    s_axis_tdata_i,
  // kind[0]
  input  wire logic                           s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // crop_left[11:0], crop_top[23:12], crop_width[35:24], crop_height[47:36]
  output logic [cwmv_pkg::DATA_W-1:0]         m_axis_tdata_o,
  // table_overflow[0]
  output logic                                m_axis_tuser_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [cwmv_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire cwmv_pkg::val_t                 cfg_data_i
);

  cwmv_pkg::cmd_t cmd;
  cwmv_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  cwmv_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i),
    .in_kind_i (s_axis_tuser_i),
    .in_ready_o(s_axis_tready_o),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  cwmv_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i         (cmd),
    .sts_o         (sts),
    .sample_i      (s_axis_tdata_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_data_o    (m_axis_tdata_o),
    .out_overflow_o(m_axis_tuser_o)
  );

endmodule
`default_nettype wire

### design/cwmv_checker.sv
// Port-level checks of the crop window mode vote block, bound to the top level.
`default_nettype none
`include "crop_window_mode_vote_assert.svh"
module cwmv_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid_i,
  input wire logic                           s_axis_tready_o,
  input wire logic [cwmv_pkg::DATA_W-1:0]    s_axis_tdata_i,
  input wire logic                           s_axis_tuser_i,
  input wire logic                           m_axis_tvalid_o,
  input wire logic                           m_axis_tready_i,
  input wire logic [cwmv_pkg::DATA_W-1:0]    m_axis_tdata_o,
  input wire logic                           m_axis_tuser_o,
  input wire logic                           cfg_valid_i,
  input wire logic                           cfg_ready_o,
  input wire logic [cwmv_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input wire cwmv_pkg::val_t                 cfg_data_i
);

  logic in_acc, out_stall;

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;

  // a stalled result stays offered
  `CWMV_ASSERT_IMP(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o)

  // every item keeps the input closed for at least the next cycle
  `CWMV_ASSERT_IMP(a_busy_after_item, clk_i, rst_ni, in_acc, !s_axis_tready_o)

  // a result is only loaded at the end of a finish, while the input is closed
  `CWMV_ASSERT(a_load_while_busy, clk_i, rst_ni,
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))

endmodule

bind crop_window_mode_vote cwmv_checker u_checker (.*);
`default_nettype wire
